// ===== sv/stif_pkg.sv =====
`timescale 1ns / 1ps
package stif_pkg;
  localparam int NUM_GROUPS = 32;
  localparam int NUM_WAYS   = 8;
  localparam int TABLE_SIZE = NUM_GROUPS * NUM_WAYS;
  localparam int CANDS      = 2 * NUM_WAYS;
  localparam int GW         = $clog2(NUM_GROUPS);
  localparam int WW         = $clog2(NUM_WAYS);
  localparam int IW         = $clog2(TABLE_SIZE);
  localparam int CW         = $clog2(CANDS);
  localparam logic [35:0] KERNEL_RESET = 36'hC00000000;
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [35:0] seg_id;
    logic [51:0] virt_seg_id;
  } req_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic        replaced;
    logic [35:0] evicted_seg_id;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FREE_RD, ST_FREE_CHK, ST_VIC_RD, ST_VIC_CHK,
    ST_WRITE, ST_FL_RD, ST_FL_CHK, ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic cand_clr;   // candidate counter to zero
    logic cand_inc;   // advance candidate counter
    logic vic_start;  // candidate counter from pointer
    logic vic_inc;    // advance victim scan
    logic rd_cand;    // read entry at candidate
    logic rd_flush;   // read entry at flush index
    logic fl_clr;     // flush index to one
    logic fl_inc;     // advance flush index
    logic fl_kill;    // invalidate flush entry if below kernel
    logic wr_free;    // write new entry at candidate
    logic wr_victim;  // write new entry over victim
    logic wr_repl;    // victim write with cast-out
    logic done;       // emit result
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_flush;
    logic cand_free;   // candidate entry invalid
    logic cand_last;   // candidate counter at last
    logic vic_user;    // candidate not kernel id
    logic vic_last;    // victim scan exhausted
    logic fl_last;     // flush index at last entry
  } sts_t;
endpackage

// ===== sv/segment_table_insert_flush_core.sv =====
`timescale 1ns / 1ps
// Channel | Signals                  | Handshake
// request | start, busy, req         | taken when start && !busy
// result  | done, result             | one cycle strobe, no stall
// config  | cfg_valid, cfg_ready, cfg_data | written when valid && ready
// Insert: idle, then a read and a check per way probed (up to 16), a read and a
// check per victim candidate checked (up to 16), then write and result.
// Flush: idle, dispatch, a read and a check per entry 1..255, then result; entries
// go through one table read port. Reset clears valid bits and pointer, loads kernel id.
// The result cannot be stalled; a new item is taken after done.
module segment_table_insert_flush_core import stif_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [35:0] cfg_data
);
  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;
  assign done = ctl.done;

  stif_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .ctl);
  stif_datapath u_dp (.clk, .rst, .req, .cfg_valid, .cfg_ready, .cfg_data,
                      .ctl, .sts, .result);
endmodule

// ===== sv/stif_datapath.sv =====
`timescale 1ns / 1ps
module stif_datapath import stif_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [35:0] cfg_data,
  input  ctl_t        ctl,
  output sts_t        sts,
  output rsp_t        result
);
  logic [TABLE_SIZE-1:0] valid;
  logic [35:0] seg_mem [TABLE_SIZE];
  logic [51:0] vseg_mem [TABLE_SIZE];
  logic [35:0] kernel_esid;
  req_t        rq;
  logic [CW-1:0] cand, vptr;
  logic [CW:0]   vcount;
  logic [IW-1:0] fidx;
  logic [35:0] rd_seg;
  logic        rd_valid;
  logic [GW-1:0] prim, sec;
  logic [IW-1:0] cidx;

  assign prim = rq.seg_id[GW-1:0];
  assign sec  = ~prim;
  assign cidx = (cand < CW'(NUM_WAYS)) ? {prim, cand[WW-1:0]} : {sec, cand[WW-1:0]};

  // Hold config and request
  always_ff @(posedge clk) begin
    if (rst) kernel_esid <= KERNEL_RESET;
    else if (cfg_valid && cfg_ready) kernel_esid <= cfg_data;
    if (ctl.load) rq <= req;
  end

  // Advance counters; the victim scan wraps back to the pointer when all are kernel
  always_ff @(posedge clk) begin
    if (rst) begin
      vptr <= '0;
    end else begin
      if (ctl.cand_clr) cand <= '0;
      else if (ctl.cand_inc) cand <= cand + 1'b1;
      else if (ctl.vic_start) begin
        cand <= vptr; vcount <= '0;
      end else if (ctl.vic_inc) begin
        cand <= cand + 1'b1; vcount <= vcount + 1'b1;
      end
      if (ctl.fl_clr) fidx <= IW'(1);
      else if (ctl.fl_inc) fidx <= fidx + 1'b1;
      if (ctl.wr_victim) vptr <= cand + 1'b1;
    end
  end

  // Read entry, registered
  always_ff @(posedge clk) begin
    if (ctl.rd_cand) rd_seg <= seg_mem[cidx];
    else if (ctl.rd_flush) rd_seg <= seg_mem[fidx];
  end
  always_ff @(posedge clk) begin
    if (ctl.rd_cand) rd_valid <= valid[cidx];
  end

  // Write table
  always_ff @(posedge clk) begin
    if (ctl.wr_free || ctl.wr_victim) begin
      seg_mem[cidx]  <= rq.seg_id;
      vseg_mem[cidx] <= rq.virt_seg_id;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (ctl.wr_free || ctl.wr_victim) valid[cidx] <= 1'b1;
    else if (ctl.fl_kill && rd_seg < kernel_esid) valid[fidx] <= 1'b0;
  end

  // Build result
  always_ff @(posedge clk) begin
    if (ctl.load) result <= '0;
    else if (ctl.wr_free || ctl.wr_victim) begin
      result.slot <= 8'(cidx);
      result.replaced <= ctl.wr_repl;
      result.evicted_seg_id <= ctl.wr_repl ? rd_seg : '0;
    end
  end

  assign sts.is_flush  = rq.req_type == REQ_FLUSH;
  assign sts.cand_free = !rd_valid;
  assign sts.cand_last = cand == CW'(CANDS - 1);
  assign sts.vic_user  = rd_seg != kernel_esid;
  assign sts.vic_last  = vcount == (CW+1)'(CANDS - 1);
  assign sts.fl_last   = fidx == IW'(TABLE_SIZE - 1);
endmodule

// ===== sv/stif_ctrl.sv =====
`timescale 1ns / 1ps
module stif_ctrl import stif_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  sts_t   sts,
  output ctl_t   ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Sequence insert and flush
  always_comb begin
    state_next = state;
    ctl = '0;
    busy = state != ST_IDLE;
    case (state)
      ST_IDLE: if (start) begin
        ctl.load = 1'b1; ctl.cand_clr = 1'b1; ctl.fl_clr = 1'b1;
        state_next = ST_FREE_RD;
      end
      ST_FREE_RD: if (sts.is_flush) state_next = ST_FL_RD;
        else begin ctl.rd_cand = 1'b1; state_next = ST_FREE_CHK; end
      ST_FREE_CHK: if (sts.cand_free) begin
        ctl.wr_free = 1'b1; state_next = ST_DONE;
      end else if (sts.cand_last) begin
        ctl.vic_start = 1'b1; state_next = ST_VIC_RD;
      end else begin
        ctl.cand_inc = 1'b1; state_next = ST_FREE_RD;
      end
      ST_VIC_RD: begin ctl.rd_cand = 1'b1; state_next = ST_VIC_CHK; end
      ST_VIC_CHK: if (sts.vic_user) state_next = ST_WRITE;
        else if (sts.vic_last) begin
          // all kernel: one more step wraps to the pointer
          ctl.vic_inc = 1'b1; state_next = ST_WRITE;
        end else begin
          ctl.vic_inc = 1'b1; state_next = ST_VIC_RD;
        end
      ST_WRITE: begin
        ctl.wr_victim = 1'b1; ctl.wr_repl = 1'b1; state_next = ST_DONE;
      end
      ST_FL_RD: begin ctl.rd_flush = 1'b1; state_next = ST_FL_CHK; end
      ST_FL_CHK: begin
        ctl.fl_kill = 1'b1;
        if (sts.fl_last) state_next = ST_DONE;
        else begin ctl.fl_inc = 1'b1; state_next = ST_FL_RD; end
      end
      ST_DONE: begin ctl.done = 1'b1; state_next = ST_IDLE; end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import stif_pkg::*;

  // Holds the table's expected contents and the results still owed by the block
  class seg_table_scoreboard;
    logic        valid_q [TABLE_SIZE];
    logic [35:0] seg_q [TABLE_SIZE];
    logic [3:0]  victim_ptr;
    logic [35:0] kernel_id;
    rsp_t        owed_results [$];
    int          errors;

    function new();
      foreach (valid_q[i]) begin
        valid_q[i] = 1'b0;
        seg_q[i] = '0;
      end
      victim_ptr = '0;
      kernel_id = KERNEL_RESET;
      errors = 0;
    endfunction

    function int cand_slot(int prim, int sec, int c);
      if (c < NUM_WAYS) return prim * NUM_WAYS + c;
      return sec * NUM_WAYS + (c - NUM_WAYS);
    endfunction

    // Apply an accepted item to the table copy and queue its result
    function void note_item(req_t r);
      rsp_t exp;
      int prim, sec, c, idx, chosen;
      bit found;
      exp = '0;
      found = 0;
      if (r.req_type == REQ_FLUSH) begin
        for (int i = 1; i < TABLE_SIZE; i++)
          if (seg_q[i] < kernel_id) valid_q[i] = 1'b0;
        owed_results.push_back(exp);
        return;
      end
      prim = int'(r.seg_id % NUM_GROUPS);
      sec = NUM_GROUPS - 1 - prim;
      for (c = 0; c < CANDS; c++) begin
        idx = cand_slot(prim, sec, c);
        if (!valid_q[idx]) begin
          valid_q[idx] = 1'b1;
          seg_q[idx] = r.seg_id;
          exp.slot = idx[7:0];
          owed_results.push_back(exp);
          return;
        end
      end
      chosen = int'(victim_ptr);
      c = chosen;
      for (int i = 0; i < CANDS; i++) begin
        if (!found && seg_q[cand_slot(prim, sec, c)] != kernel_id) begin
          found = 1;
          chosen = c;
        end
        if (!found) c = (c + 1) % CANDS;
      end
      victim_ptr = 4'((chosen + 1) % CANDS);
      idx = cand_slot(prim, sec, chosen);
      exp.slot = idx[7:0];
      exp.replaced = valid_q[idx];
      exp.evicted_seg_id = valid_q[idx] ? seg_q[idx] : '0;
      valid_q[idx] = 1'b1;
      seg_q[idx] = r.seg_id;
      owed_results.push_back(exp);
    endfunction

    // Compare a result against the oldest expectation
    function void check_result(rsp_t got);
      rsp_t exp;
      if (owed_results.size() == 0) begin
        $error("unexpected result slot=%0d", got.slot);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.slot !== exp.slot) begin
        $error("slot exp %0d got %0d", exp.slot, got.slot);
        errors++;
      end
      if (got.replaced !== exp.replaced) begin
        $error("replaced exp %0d got %0d", exp.replaced, got.replaced);
        errors++;
      end
      if (got.evicted_seg_id !== exp.evicted_seg_id) begin
        $error("evicted_seg_id exp %h got %h", exp.evicted_seg_id, got.evicted_seg_id);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [35:0] cfg_data = '0;

  seg_table_scoreboard sb = new();
  int sender_idle_pct = 0;
  longint cycle_count = 0;
  logic [35:0] seg_pool [8];

  segment_table_insert_flush_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Check every result strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [35:0] rand_seg();
    return 36'({$urandom(), $urandom()});
  endfunction

  function automatic logic [51:0] rand_vseg();
    return 52'({$urandom(), $urandom()});
  endfunction

  // Present one item and hold it until the block takes it; start stays high after
  task automatic send_item(req_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(r);
  endtask

  task automatic send_insert(logic [35:0] seg, logic [51:0] vseg);
    req_t r;
    r.req_type = REQ_INSERT;
    r.seg_id = seg;
    r.virt_seg_id = vseg;
    send_item(r);
  endtask

  task automatic send_flush();
    req_t r;
    r.req_type = REQ_FLUSH;
    r.seg_id = rand_seg();
    r.virt_seg_id = rand_vseg();
    send_item(r);
  endtask

  // Drop start, wait for all results, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_kernel(logic [35:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.kernel_id = v;
    cfg_valid <= 1'b0;
  endtask

  // Random phase: half of the inserts come from a small pool so groups fill up
  task automatic random_phase(int n);
    logic [35:0] s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) begin
        send_flush();
      end else begin
        case ($urandom_range(3))
          0: s = rand_seg();
          1: s = sb.kernel_id;
          default: s = seg_pool[$urandom_range(7)];
        endcase
        send_insert(s, rand_vseg());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, kernel fill, full groups, flush
    send_insert('0, '0);
    send_insert('1, '1);
    send_insert(36'h0_0000_0000, 52'hF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 17; i++) send_insert(KERNEL_RESET, rand_vseg());
    send_insert(36'h8_0000_0020, 52'h1);
    send_flush();
    send_insert(36'h4, 52'h5);
    drain();

    foreach (seg_pool[i]) seg_pool[i] = rand_seg();
    write_kernel('0);
    sender_idle_pct = 33;
    random_phase(300);
    drain();
    write_kernel('1);
    sender_idle_pct = 50;
    random_phase(300);
    drain();
    write_kernel(rand_seg());
    sender_idle_pct = 0;
    random_phase(350);
    drain();

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
